// ===== design/kis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kis_pkg
// Shared types, codes and sizing constants of the k-mer index search block.
// ----------------------------------------------------------------------------
package kis_pkg;

  // default sizes
  localparam int DEF_MAX_ENTRIES  = 64;
  localparam int DEF_MAX_POSTINGS = 4096;
  localparam int DEF_DICT_SIZE    = 65536;

  // most hits reported for one query
  localparam int MAX_OUT   = 64;
  localparam int OUT_CW    = 7;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // request types
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // alphabet modes
  localparam logic MODE_AMINO = 1'b0;
  localparam logic MODE_NUCL  = 1'b1;

  // word shape per mode
  localparam logic [3:0] K_AMINO = 4'd3;
  localparam logic [3:0] K_NUCL  = 4'd8;
  localparam logic [4:0] B_AMINO = 5'd20;
  localparam logic [4:0] B_NUCL  = 5'd4;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [1:0] ST_POST_FULL  = 2'd2;

  // register indexes
  localparam logic REG_ALPHABET_MODE = 1'b0;

endpackage

// ===== design/kis_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kis_req_if
// Letter request channel: valid/ready with one letter per transaction.
// ----------------------------------------------------------------------------
interface kis_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [4:0]  letter;
  logic        last_letter;
  logic [15:0] seq_id;

  modport source (output valid, req_type, letter, last_letter, seq_id, input ready);
  modport sink   (input valid, req_type, letter, last_letter, seq_id, output ready);
endinterface

// ===== design/kis_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kis_res_if
// Result channel: valid/ready with one hit or status per transaction.
// ----------------------------------------------------------------------------
interface kis_res_if;
  logic        valid;
  logic        ready;
  logic        hit_valid;
  logic [15:0] hit_seq_id;
  logic [15:0] word_count;
  logic        last;
  logic [1:0]  status;

  modport source (output valid, hit_valid, hit_seq_id, word_count, last, status,
                  input ready);
  modport sink   (input valid, hit_valid, hit_seq_id, word_count, last, status,
                  output ready);
endinterface

// ===== design/kmer_index_similarity_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_index_similarity_search
// Builds a k-mer index of database sequences and ranks entries against a query.
// ----------------------------------------------------------------------------
// Usage:
//  req  : one letter code per transaction. An add letter with last_letter set
//         ends a database sequence and yields one status result. A query
//         letter with last_letter set yields the ranked hits (up to 64, the
//         final one marked last) or one empty marker.
//  res  : results, held in an output register until taken; a stalled
//         receiver only holds the block at the next result it must emit.
//  APB  : alphabet_mode at address 0; write only while idle.
// Operation:
//  A query word walks its posting list: for each posting, a posting read,
//  then a counter read-modify-write through the counter RAM.
//  When there are hits, a final query letter sweeps the counter RAM
//  2 + H times over the E stored entries, H the number of hits.
// Reset:
//  After rst the list head RAM is cleared one word per cycle,
//  while req.ready stays low; APB writes are taken throughout.
// ----------------------------------------------------------------------------
module kmer_index_similarity_search
  import kis_pkg::*;
#(
  parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
  parameter int MAX_POSTINGS = DEF_MAX_POSTINGS,
  parameter int DICT_SIZE    = DEF_DICT_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  kis_req_if.sink     req,
  kis_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ECW = $clog2(MAX_ENTRIES + 1);
  localparam int PAW = (MAX_POSTINGS > 1) ? $clog2(MAX_POSTINGS) : 1;
  localparam int PW  = $clog2(MAX_POSTINGS + 1);
  localparam int HAW = (DICT_SIZE > 1) ? $clog2(DICT_SIZE) : 1;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ADD_WR = 4'd2;
  localparam logic [3:0] S_Q_HEAD = 4'd3;
  localparam logic [3:0] S_PDATA  = 4'd4;
  localparam logic [3:0] S_CUPD   = 4'd5;
  localparam logic [3:0] S_FINAL  = 4'd6;
  localparam logic [3:0] S_TOP    = 4'd7;
  localparam logic [3:0] S_CNT    = 4'd8;
  localparam logic [3:0] S_PASS   = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;
  localparam logic [3:0] S_MARK   = 4'd11;

  logic [3:0]  state;
  logic [HAW-1:0] clr_idx;

  // configuration and per-sequence state
  logic        mode;
  logic [15:0] win;
  logic [3:0]  run;
  logic [3:0]  slen;
  logic [1:0]  ovf;
  logic [MAX_ENTRIES-1:0] cvalid;

  // index state
  logic [ECW-1:0] ec;
  logic [PW-1:0]  pc;

  // current item
  logic        cur_req;
  logic        cur_last;
  logic [15:0] cur_sid;
  logic [HAW-1:0] cur_word;

  // list walk
  logic [EW-1:0] pe;
  logic [PW-1:0] pnext;

  // ranking sweep
  logic [ECW-1:0] sidx;
  logic           dv;
  logic [EW-1:0]  didx;
  logic [15:0]    top;
  logic [15:0]    minu;
  logic [ECW-1:0] n_hits;
  logic [OUT_CW-1:0] n_emit;
  logic [OUT_CW-1:0] k_out;
  logic [15:0]    bc;
  logic [EW-1:0]  bi;
  logic           bfound;
  logic [15:0]    prev_c;
  logic [EW-1:0]  prev_i;
  logic           have_prev;

  // output register
  logic        ov;
  logic        o_hit;
  logic [15:0] o_id;
  logic [15:0] o_cnt;
  logic        o_last;
  logic [1:0]  o_st;

  // RAM ports
  logic           h_we;
  logic [HAW-1:0] h_waddr, h_raddr;
  logic [PW-1:0]  h_wdata, h_rdata;
  logic           p_we;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic [PW+EW-1:0] p_wdata, p_rdata;
  logic           c_we;
  logic [EW-1:0]  c_waddr, c_raddr;
  logic [15:0]    c_wdata, c_rdata;
  logic           i_we;
  logic [15:0]    i_rdata;

  // ---- APB ----
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ALPHABET_MODE);
  assign prdata = (paddr[2] == REG_ALPHABET_MODE) ? {31'd0, mode} : 32'd0;

  // ---- word window ----
  logic [3:0]  kk;
  logic        let_ok;
  logic [15:0] win_next;
  logic [3:0]  run_next;
  logic [3:0]  slen_next;
  logic [15:0] word_next;
  logic        word_ok;

  always_comb begin
    kk     = (mode == MODE_NUCL) ? K_NUCL : K_AMINO;
    let_ok = (mode == MODE_NUCL) ? (req.letter < B_NUCL) : (req.letter < B_AMINO);
    if (!let_ok) begin
      win_next = 16'd0;
    end else if (mode == MODE_NUCL) begin
      win_next = {win[13:0], req.letter[1:0]};
    end else begin
      win_next = {1'b0, win[9:0], req.letter};
    end
    if (mode == MODE_NUCL) begin
      word_next = win_next;
    end else begin
      word_next = {11'd0, win_next[14:10]} * 16'd400
                + {11'd0, win_next[9:5]} * 16'd20
                + {11'd0, win_next[4:0]};
    end
    run_next  = !let_ok ? 4'd0 : ((run < kk) ? run + 4'd1 : run);
    slen_next = (slen < kk) ? slen + 4'd1 : slen;
    word_ok   = (run_next >= kk) && ({1'b0, word_next} < 17'(DICT_SIZE));
  end

  // ---- counter sweep ----
  logic        sweeping;
  logic        sweep_issue;
  logic [15:0] cval;
  logic        after_prev;
  logic        out_free;
  logic        o_load;

  assign sweeping    = (state == S_TOP) || (state == S_CNT) || (state == S_PASS);
  assign sweep_issue = sweeping && (sidx < ec);
  assign cval        = cvalid[didx] ? c_rdata : 16'd0;
  assign after_prev  = !have_prev || (cval < prev_c) ||
                       ((cval == prev_c) && (didx > prev_i));
  assign out_free    = !ov || res.ready;

  // output register loads a new result this cycle
  assign o_load = out_free &&
                  (((state == S_FINAL) && cur_last && (cur_req == REQ_ADD)) ||
                   (state == S_EMIT) || (state == S_MARK));

  // walk counter value
  logic [15:0] wval;
  assign wval = cvalid[pe] ? c_rdata : 16'd0;

  // ---- RAM port control ----
  always_comb begin
    h_we    = 1'b0;
    h_waddr = cur_word;
    h_wdata = pc + PW'(1);
    if (state == S_CLR) begin
      h_we    = 1'b1;
      h_waddr = clr_idx;
      h_wdata = '0;
    end else if (state == S_ADD_WR) begin
      h_we = 1'b1;
    end
    h_raddr = word_next[HAW-1:0];

    p_we    = (state == S_ADD_WR);
    p_waddr = pc[PAW-1:0];
    p_wdata = {h_rdata, ec[EW-1:0]};
    if (state == S_Q_HEAD) begin
      p_raddr = PAW'(h_rdata - PW'(1));
    end else begin
      p_raddr = PAW'(pnext - PW'(1));
    end

    c_we    = (state == S_CUPD);
    c_waddr = pe;
    c_wdata = (wval < CNT_MAX) ? wval + 16'd1 : wval;
    c_raddr = sweeping ? sidx[EW-1:0] : p_rdata[EW-1:0];

    i_we = (state == S_FINAL) && out_free && cur_last && (cur_req == REQ_ADD) &&
           (slen >= kk) && (ec < ECW'(MAX_ENTRIES));
  end

  kis_ram #(.WIDTH(PW), .DEPTH(DICT_SIZE)) u_heads (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  kis_ram #(.WIDTH(PW + EW), .DEPTH(MAX_POSTINGS)) u_posts (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  kis_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_counts (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  kis_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_ids (
    .clk(clk), .we(i_we), .waddr(ec[EW-1:0]), .wdata(cur_sid),
    .raddr(bi), .rdata(i_rdata)
  );

  // ---- handshake outputs ----
  assign req.ready      = (state == S_IDLE);
  assign res.valid      = ov;
  assign res.hit_valid  = o_hit;
  assign res.hit_seq_id = o_id;
  assign res.word_count = o_cnt;
  assign res.last       = o_last;
  assign res.status     = o_st;

  // final add status
  logic [1:0] ovf_fin;
  assign ovf_fin = ovf | {1'b0, (slen >= kk) && (ec >= ECW'(MAX_ENTRIES))};

  // ---- control sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      mode      <= MODE_AMINO;
      win       <= '0;
      run       <= '0;
      slen      <= '0;
      ovf       <= '0;
      cvalid    <= '0;
      ec        <= '0;
      pc        <= '0;
      dv        <= 1'b0;
      ov        <= 1'b0;
      have_prev <= 1'b0;
      bfound    <= 1'b0;
    end else begin
      if (ov && res.ready && !o_load) begin
        ov <= 1'b0;
      end

      // sweep pipeline over the counter RAM
      if (sweeping) begin
        dv   <= sweep_issue;
        didx <= sidx[EW-1:0];
        if (sweep_issue) begin
          sidx <= sidx + ECW'(1);
        end
      end

      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + HAW'(1);
          if (clr_idx == HAW'(DICT_SIZE - 1)) begin
            state <= S_IDLE;
          end
        end

        // accept a letter and update the window
        S_IDLE: begin
          if (req.valid) begin
            win      <= win_next;
            run      <= run_next;
            slen     <= slen_next;
            cur_req  <= req.req_type;
            cur_last <= req.last_letter;
            cur_sid  <= req.seq_id;
            cur_word <= word_next[HAW-1:0];
            state    <= S_FINAL;
            if (word_ok) begin
              if (req.req_type == REQ_QUERY) begin
                state <= S_Q_HEAD;
              end else if (ec >= ECW'(MAX_ENTRIES)) begin
                ovf[0] <= 1'b1;
              end else if (pc >= PW'(MAX_POSTINGS)) begin
                ovf[1] <= 1'b1;
              end else begin
                state <= S_ADD_WR;
              end
            end
          end
        end

        S_ADD_WR: begin
          pc    <= pc + PW'(1);
          state <= S_FINAL;
        end

        S_Q_HEAD: begin
          state <= (h_rdata != '0) ? S_PDATA : S_FINAL;
        end

        S_PDATA: begin
          pe    <= p_rdata[EW-1:0];
          pnext <= p_rdata[PW+EW-1:EW];
          state <= S_CUPD;
        end

        // counter increment done by the RAM write port
        S_CUPD: begin
          cvalid[pe] <= 1'b1;
          state      <= (pnext != '0) ? S_PDATA : S_FINAL;
        end

        S_FINAL: begin
          if (!cur_last) begin
            state <= S_IDLE;
          end else if (cur_req == REQ_ADD) begin
            if (out_free) begin
              if (i_we) begin
                ec <= ec + ECW'(1);
              end
              ov     <= 1'b1;
              o_hit  <= 1'b0;
              o_id   <= '0;
              o_cnt  <= '0;
              o_last <= 1'b1;
              o_st   <= ovf_fin[0] ? ST_TABLE_FULL :
                        (ovf_fin[1] ? ST_POST_FULL : ST_OK);
              win    <= '0;
              run    <= '0;
              slen   <= '0;
              ovf    <= '0;
              cvalid <= '0;
              state  <= S_IDLE;
            end
          end else if (ec == '0) begin
            state <= S_MARK;
          end else begin
            sidx  <= '0;
            dv    <= 1'b0;
            top   <= '0;
            state <= S_TOP;
          end
        end

        // highest count
        S_TOP: begin
          if (dv && (cval > top)) begin
            top <= cval;
          end
          if (!sweep_issue && !dv) begin
            if (top < 16'd2) begin
              state <= S_MARK;
            end else begin
              minu   <= (top[15:2] == '0) ? 16'd1 : (top >> 1) - 16'd1;
              sidx   <= '0;
              n_hits <= '0;
              state  <= S_CNT;
            end
          end
        end

        // number of qualifying entries
        S_CNT: begin
          if (dv && (cval >= minu)) begin
            n_hits <= n_hits + ECW'(1);
          end
          if (!sweep_issue && !dv) begin
            n_emit    <= (n_hits > ECW'(MAX_OUT)) ? OUT_CW'(MAX_OUT) : OUT_CW'(n_hits);
            k_out     <= '0;
            have_prev <= 1'b0;
            bfound    <= 1'b0;
            sidx      <= '0;
            state     <= S_PASS;
          end
        end

        // next entry in rank order
        S_PASS: begin
          if (dv && (cval >= minu) && after_prev && (!bfound || (cval > bc))) begin
            bfound <= 1'b1;
            bc     <= cval;
            bi     <= didx;
          end
          if (!sweep_issue && !dv) begin
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            ov     <= 1'b1;
            o_hit  <= 1'b1;
            o_id   <= i_rdata;
            o_cnt  <= bc;
            o_last <= (OUT_CW'(k_out + OUT_CW'(1)) == n_emit);
            o_st   <= ST_OK;
            if (OUT_CW'(k_out + OUT_CW'(1)) == n_emit) begin
              win    <= '0;
              run    <= '0;
              slen   <= '0;
              ovf    <= '0;
              cvalid <= '0;
              state  <= S_IDLE;
            end else begin
              prev_c    <= bc;
              prev_i    <= bi;
              have_prev <= 1'b1;
              bfound    <= 1'b0;
              k_out     <= k_out + OUT_CW'(1);
              sidx      <= '0;
              state     <= S_PASS;
            end
          end
        end

        S_MARK: begin
          if (out_free) begin
            ov     <= 1'b1;
            o_hit  <= 1'b0;
            o_id   <= '0;
            o_cnt  <= '0;
            o_last <= 1'b1;
            o_st   <= ST_OK;
            win    <= '0;
            run    <= '0;
            slen   <= '0;
            ovf    <= '0;
            cvalid <= '0;
            state  <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // register write: new mode, per-sequence state cleared
      if (cfg_wr) begin
        mode   <= pwdata[0];
        win    <= '0;
        run    <= '0;
        slen   <= '0;
        ovf    <= '0;
        cvalid <= '0;
      end
    end
  end

endmodule

// ===== design/kis_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kis_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kis_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/kis_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kis_checker
// Port-level checks of the k-mer index search block, bound to the top level.
// ----------------------------------------------------------------------------
module kis_checker
  import kis_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_hit_valid,
  input logic [15:0] res_hit_seq_id,
  input logic [15:0] res_word_count,
  input logic        res_last,
  input logic [1:0]  res_status,
  input logic        pready
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_hit_seq_id) &&
      $stable(res_word_count) && $stable(res_last) && $stable(res_status))
    else $error("result changed under stall");

  // hits always carry ok status and a nonzero count
  a_hit: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_hit_valid |-> res_status == ST_OK && res_word_count != 16'd0)
    else $error("bad hit result");

  // status and marker results are single, empty transactions
  a_stat: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_hit_valid |-> res_last && res_hit_seq_id == 16'd0 &&
      res_word_count == 16'd0)
    else $error("bad status result");

  // status code in range
  a_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_status == ST_OK || res_status == ST_TABLE_FULL ||
      res_status == ST_POST_FULL)
    else $error("bad status code");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind kmer_index_similarity_search kis_checker u_kis_checker (
  .clk(clk),
  .rst(rst),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .res_hit_valid(res.hit_valid),
  .res_hit_seq_id(res.hit_seq_id),
  .res_word_count(res.word_count),
  .res_last(res.last),
  .res_status(res.status),
  .pready(pready)
);

// ===== verif/tb_kmer_index_similarity_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kmer_index_similarity_search
// Self-checking bench for the k-mer index search block. Letters are streamed
// in through the request channel and a scoreboard predicts every status, hit
// and empty-search result. The run covers both alphabet modes, short and
// broken words, mixed request types and ranked searches with tied counts,
// with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_kmer_index_similarity_search;
  import kis_pkg::*;

  typedef struct {
    logic        req_type;
    logic [4:0]  letter;
    logic        last_letter;
    logic [15:0] seq_id;
  } letter_t;

  typedef struct {
    logic        hit_valid;
    logic [15:0] hit_seq_id;
    logic [15:0] word_count;
    logic        last;
    logic [1:0]  status;
  } result_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  kis_req_if req_ch ();
  kis_res_if res_ch ();

  kmer_index_similarity_search dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // stimulus and scoreboard storage
  letter_t letter_q[$];
  result_t hit_q[$];
  letter_t cur_letter;
  int      letters_queued;
  int      letters_taken;
  int      errors;
  int      send_idle;
  int      recv_idle;

  // index shadow
  logic        mode;
  int unsigned window;
  int unsigned run_len;
  int unsigned seq_len;
  int unsigned n_entries;
  logic [15:0] entry_id[64];
  logic [12:0] head[65536];
  logic [12:0] post_link[4096];
  logic [6:0]  post_owner[4096];
  int unsigned n_postings;
  int unsigned shared[64];
  logic [1:0]  ovf;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // known values on every input from time zero
  initial begin
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_ADD;
    req_ch.letter      = '0;
    req_ch.last_letter = 1'b0;
    req_ch.seq_id      = '0;
    res_ch.ready       = 1'b0;
  end

  function automatic void clear_seq();
    window  = 0;
    run_len = 0;
    seq_len = 0;
    ovf     = 2'b00;
    foreach (shared[i]) shared[i] = 0;
  endfunction

  function automatic void push_result(logic hv, logic [15:0] id, logic [15:0] cnt,
                                      logic lst, logic [1:0] st);
    result_t r;
    r.hit_valid  = hv;
    r.hit_seq_id = id;
    r.word_count = cnt;
    r.last       = lst;
    r.status     = st;
    hit_q = {hit_q, r};
  endfunction

  // rank entries by shared words and queue the hits or the empty marker
  function automatic void rank_hits();
    int unsigned top;
    int unsigned cutoff;
    int unsigned n;
    int          order[64];
    int          j;
    top = 0;
    n   = 0;
    if (n_entries == 0) begin
      push_result(1'b0, 16'd0, 16'd0, 1'b1, ST_OK);
      return;
    end
    for (int i = 0; i < n_entries; i++)
      if (shared[i] > top) top = shared[i];
    if (top < 2) begin
      push_result(1'b0, 16'd0, 16'd0, 1'b1, ST_OK);
      return;
    end
    cutoff = top / 2 - 1;
    if (cutoff == 0) cutoff = 1;
    for (int i = 0; i < n_entries; i++) begin
      if (shared[i] < cutoff) continue;
      j = n;
      while (j > 0 && shared[order[j-1]] < shared[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
      n++;
    end
    if (n > MAX_OUT) n = MAX_OUT;
    for (int k = 0; k < n; k++)
      push_result(1'b1, entry_id[order[k]], shared[order[k]][15:0], k + 1 == n, ST_OK);
  endfunction

  // one accepted letter through the index shadow
  function automatic void index_step(letter_t it);
    int unsigned klen;
    int unsigned base;
    int unsigned modv;
    int unsigned p;
    int unsigned e;
    logic [1:0]  st;
    klen = (mode == MODE_NUCL) ? K_NUCL : K_AMINO;
    base = (mode == MODE_NUCL) ? B_NUCL : B_AMINO;
    modv = (mode == MODE_NUCL) ? 65536 : 8000;
    if (it.letter < base) begin
      window = (window * base + it.letter) % modv;
      if (run_len < klen) run_len++;
    end else begin
      window  = 0;
      run_len = 0;
    end
    if (seq_len < klen) seq_len++;

    // word complete: record a posting or count matches
    if (run_len >= klen) begin
      if (it.req_type == REQ_ADD) begin
        if (n_entries >= 64) ovf[0] = 1'b1;
        else if (n_postings >= 4096) ovf[1] = 1'b1;
        else begin
          post_link[n_postings]  = head[window];
          post_owner[n_postings] = 7'(n_entries);
          n_postings++;
          head[window] = 13'(n_postings);
        end
      end else begin
        p = head[window];
        while (p != 0) begin
          e = post_owner[p-1];
          if (shared[e] < 16'hFFFF) shared[e]++;
          p = post_link[p-1];
        end
      end
    end

    if (!it.last_letter) return;
    if (it.req_type == REQ_ADD) begin
      if (seq_len >= klen) begin
        if (n_entries >= 64) ovf[0] = 1'b1;
        else begin
          entry_id[n_entries] = it.seq_id;
          n_entries++;
        end
      end
      st = ovf[0] ? ST_TABLE_FULL : (ovf[1] ? ST_POST_FULL : ST_OK);
      push_result(1'b0, 16'd0, 16'd0, 1'b1, st);
    end else begin
      rank_hits();
    end
    clear_seq();
  endfunction

  // driver: one letter per transaction
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        index_step(cur_letter);
        letters_taken++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (letter_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur_letter = letter_q.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.req_type    <= cur_letter.req_type;
          req_ch.letter      <= cur_letter.letter;
          req_ch.last_letter <= cur_letter.last_letter;
          req_ch.seq_id      <= cur_letter.seq_id;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (hit_q.size() == 0) begin
          $display("%0t: unexpected result hv=%0d id=%0d cnt=%0d last=%0d st=%0d",
                   $time, res_ch.hit_valid, res_ch.hit_seq_id, res_ch.word_count,
                   res_ch.last, res_ch.status);
          errors++;
        end else begin
          want = hit_q.pop_front();
          if (res_ch.hit_valid !== want.hit_valid || res_ch.hit_seq_id !== want.hit_seq_id ||
              res_ch.word_count !== want.word_count || res_ch.last !== want.last ||
              res_ch.status !== want.status) begin
            $display("%0t: mismatch expected hv=%0d id=%0d cnt=%0d last=%0d st=%0d",
                     $time, want.hit_valid, want.hit_seq_id, want.word_count,
                     want.last, want.status);
            $display("%0t:            actual hv=%0d id=%0d cnt=%0d last=%0d st=%0d",
                     $time, res_ch.hit_valid, res_ch.hit_seq_id, res_ch.word_count,
                     res_ch.last, res_ch.status);
            errors++;
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic void add_letter(logic rt, logic [4:0] l, logic lst, logic [15:0] id);
    letter_t it;
    it.req_type    = rt;
    it.letter      = l;
    it.last_letter = lst;
    it.seq_id      = id;
    letter_q = {letter_q, it};
    letters_queued++;
  endfunction

  // whole sequence from a letter string of codes
  function automatic void add_seq(logic rt, int codes[$], logic [15:0] id);
    foreach (codes[i]) add_letter(rt, 5'(codes[i]), i == codes.size() - 1, id);
  endfunction

  // mostly well-formed sequences with random content, some noise
  function automatic void add_random(int count);
    int          made;
    int          len;
    int          base;
    logic        rt;
    logic [15:0] id;
    logic [4:0]  l;
    made = 0;
    base = (mode == MODE_NUCL) ? B_NUCL : B_AMINO;
    while (made < count) begin
      if ($urandom_range(99) < 10) begin
        add_letter(1'($urandom_range(1)), 5'($urandom_range(31)), 1'($urandom_range(1)),
                   16'($urandom_range(16'hFFFF)));
        made++;
      end else begin
        rt  = 1'($urandom_range(1));
        id  = 16'($urandom_range(16'hFFFF));
        len = (mode == MODE_NUCL) ? $urandom_range(14, 1) : $urandom_range(10, 1);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(99) < 10) l = 5'($urandom_range(31));
          else if ($urandom_range(1)) l = 5'($urandom_range(3));
          else l = 5'($urandom_range(base - 1));
          if ($urandom_range(99) < 5) rt = ~rt;
          add_letter(rt, l, i == len - 1, id);
        end
        made += len;
      end
    end
  endfunction

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == {REG_ALPHABET_MODE, 2'b00}) begin
      mode = data[0];
      clear_seq();
    end
  endtask

  // wait until every letter is taken and every result checked
  task automatic drain();
    while (letters_taken != letters_queued || hit_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // timeout
  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // phases
  initial begin
    errors         = 0;
    letters_queued = 0;
    letters_taken  = 0;
    n_entries      = 0;
    n_postings     = 0;
    mode           = MODE_AMINO;
    foreach (head[i]) head[i] = '0;
    clear_seq();
    send_idle = 34;
    recv_idle = 73;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    reg_write({REG_ALPHABET_MODE, 2'b00}, 32'(MODE_AMINO));

    // amino: directed corner cases, then random
    add_seq(REQ_QUERY, '{1, 2, 3}, 16'd0);              // empty index
    add_seq(REQ_ADD, '{31, 0}, 16'd7);                   // too short, broken
    add_seq(REQ_ADD, '{0, 19, 19, 0}, 16'hFFFF);
    add_seq(REQ_ADD, '{5, 6, 7, 5, 6, 7}, 16'h0000);
    add_seq(REQ_QUERY, '{5, 6, 7}, 16'h1234);            // one hit, count 2
    add_seq(REQ_QUERY, '{20, 5}, 16'd0);                 // short word
    add_letter(REQ_ADD, 5'd5, 1'b0, 16'd1);              // mixed request types
    add_letter(REQ_QUERY, 5'd6, 1'b0, 16'd2);
    add_letter(REQ_QUERY, 5'd7, 1'b1, 16'd3);
    add_seq(REQ_QUERY, '{0, 19, 19}, 16'd0);             // top below 2
    add_seq(REQ_ADD, '{5, 6, 7, 5, 6, 7, 5, 6, 7}, 16'hA5A5);
    add_seq(REQ_QUERY, '{5, 6, 7, 5, 6, 7}, 16'd0);
    add_random(60);
    drain();

    // nucleotide: receiver mostly ready, sender gappy
    send_idle = 73;
    recv_idle = 34;
    reg_write({REG_ALPHABET_MODE, 2'b00}, 32'(MODE_NUCL));
    add_seq(REQ_ADD, '{0, 1, 2, 3, 3, 2, 1, 0, 3}, 16'h5A5A);
    add_seq(REQ_QUERY, '{0, 1, 2, 3, 3, 2, 1, 0, 3}, 16'd0);
    add_seq(REQ_QUERY, '{0, 1, 2, 3, 4, 3, 2, 1, 0}, 16'd0);
    add_random(40);
    drain();

    // amino, no idling: tied entries ranked by position, then random
    send_idle = 0;
    recv_idle = 0;
    reg_write({REG_ALPHABET_MODE, 2'b00}, 32'(MODE_AMINO));
    for (int i = 0; i < 4; i++)
      add_seq(REQ_ADD, '{1, 2, 3, 1, 2, 3}, 16'($urandom_range(16'hFFFF)));
    add_seq(REQ_QUERY, '{1, 2, 3, 1, 2, 3}, 16'd0);
    add_random(40);
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
